[design/pmv_pkg.sv]
// ============================================================================
// pmv_pkg: shared constants, sine table and lookup for the PM voice
// Holds the register map, reset values, fixed-point constants and the
// quarter-wave sine table with its full-cycle lookup function.
// ============================================================================
`default_nettype none

package pmv_pkg;

    // Structural defaults and fixed formats
    localparam int MAX_OSCILLATORS  = 8;
    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_BITS      = 16;

    localparam int IDX_BITS  = $clog2(SINE_TABLE_DEPTH);
    localparam int QTR       = SINE_TABLE_DEPTH / 4;
    localparam int QTR_BITS  = IDX_BITS - 2;
    localparam int SINE_BITS = 16;
    localparam int INDEX_BITS = 24;
    localparam int STEP_BITS  = 17;
    localparam int GAIN_BITS  = 16;
    localparam int COUNT_BITS = 3;

    // Radians Q20 times 1/(2 pi) Q32 gives a phase at bit 52
    localparam int RAD_PHASE_TOP = 51;
    localparam int RAD_PHASE_LOW = 52 - PHASE_BITS;
    localparam int RAD_FRAC_BITS = 15;
    localparam int OUT_SHIFT     = 31 - SAMPLE_BITS;

    localparam logic signed [30:0] INV_TWO_PI = 31'sd683565276;
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [INDEX_BITS-1:0] INDEX_MAX = 24'sh7FFFFF;
    localparam logic signed [INDEX_BITS-1:0] INDEX_MIN = 24'sh800000;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_STEP     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_STEP   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_MODS      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SINE_OF_INDEX = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_INDEX   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_GAIN      = 3'd5;

    // Register reset values
    localparam logic [31:0]                  RST_BASE_STEP     = 32'd4473924;
    localparam logic [31:0]                  RST_OFFSET_STEP   = 32'd178957;
    localparam logic [COUNT_BITS-1:0]        RST_NUM_MODS      = 3'd3;
    localparam logic                         RST_SINE_OF_INDEX = 1'b0;
    localparam logic signed [INDEX_BITS-1:0] RST_START_INDEX   = 24'sd734003;
    localparam logic [GAIN_BITS-1:0]         RST_OUT_GAIN      = 16'd16384;

    typedef logic [QTR-1:0][14:0] t_qtab;

    // sin(m/QTR * pi/2) in Q1.15 by a Q30 Taylor series, rounded half up
    function automatic logic [14:0] quarter_sine(input int mq);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] r;
        t    = (64'(mq) * 64'd4 * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        t2   = (t * t) >> 30;
        term = t;
        acc  = t;
        term = ((term * t2) >> 30) / 64'd6;
        acc  = acc - term;
        term = ((term * t2) >> 30) / 64'd20;
        acc  = acc + term;
        term = ((term * t2) >> 30) / 64'd42;
        acc  = acc - term;
        term = ((term * t2) >> 30) / 64'd72;
        acc  = acc + term;
        term = ((term * t2) >> 30) / 64'd110;
        acc  = acc - term;
        r    = (acc + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[14:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int i = 0; i < QTR; i++) begin
            tab[i] = quarter_sine(i);
        end
        return tab;
    endfunction

    localparam t_qtab QSINE = build_qtab();

    // Full-cycle sine from the quarter table, Q1.15
    function automatic logic signed [SINE_BITS-1:0] sine_lookup(
        input logic [IDX_BITS-1:0] idx
    );
        logic [QTR_BITS-1:0]  m;
        logic [SINE_BITS-1:0] mag;
        m = idx[QTR_BITS-1:0];
        if (idx[QTR_BITS]) begin
            if (m == '0) begin
                mag = 16'd32767;
            end else begin
                mag = {1'b0, QSINE[QTR_BITS'(~m + 1'b1)]};
            end
        end else begin
            mag = {1'b0, QSINE[m]};
        end
        if (idx[IDX_BITS-1]) begin
            return -$signed(mag);
        end
        return $signed(mag);
    endfunction

endpackage

`default_nettype wire

[design/pmv_cell.sv]
// ============================================================================
// pmv_cell: one modulator oscillator of the chain
// Holds one modulator phase. When the sample token passes and the cell is
// still inside the active count, adds its sine to the running sum and advances
// its phase; on every pass it hands the token on with the next harmonic step.
// ============================================================================
`default_nettype none

module pmv_cell #(
    parameter int SUM_BITS = 19
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic [pmv_pkg::COUNT_BITS-1:0]    i_remaining,
    input  wire logic [pmv_pkg::PHASE_BITS-1:0]    i_inc,
    input  wire logic signed [SUM_BITS-1:0]        i_sum,
    input  wire logic [pmv_pkg::PHASE_BITS-1:0]    i_base_step,
    output logic                                   o_valid,
    output logic [pmv_pkg::COUNT_BITS-1:0]         o_remaining,
    output logic [pmv_pkg::PHASE_BITS-1:0]         o_inc,
    output logic signed [SUM_BITS-1:0]             o_sum
);

    logic [pmv_pkg::PHASE_BITS-1:0]      r_phase;
    logic                                r_valid;
    logic [pmv_pkg::COUNT_BITS-1:0]      r_remaining;
    logic [pmv_pkg::PHASE_BITS-1:0]      r_inc;
    logic signed [SUM_BITS-1:0]          r_sum;
    logic                                w_active;
    logic signed [pmv_pkg::SINE_BITS-1:0] w_sine;
    logic signed [SUM_BITS-1:0]          w_sine_ext;

    // Sine of the phase before this sample's advance
    assign w_active   = i_valid && (i_remaining != '0);
    assign w_sine     = pmv_pkg::sine_lookup(
                            r_phase[pmv_pkg::PHASE_BITS-1 -: pmv_pkg::IDX_BITS]);
    assign w_sine_ext = {{(SUM_BITS - pmv_pkg::SINE_BITS){w_sine[pmv_pkg::SINE_BITS-1]}},
                         w_sine};

    // Advance the phase and the token flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
            if (w_active) begin
                r_phase <= r_phase + i_inc;
            end
        end
    end

    // Hand the token payload to the next cell
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_inc <= i_inc + i_base_step;
            if (w_active) begin
                r_sum       <= i_sum + w_sine_ext;
                r_remaining <= i_remaining - 1'b1;
            end else begin
                r_sum       <= i_sum;
                r_remaining <= i_remaining;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_remaining = r_remaining;
    assign o_inc       = r_inc;
    assign o_sum       = r_sum;

endmodule

`default_nettype wire

[design/pmv_mix.sv]
// ============================================================================
// pmv_mix: modulation, carrier sine, gain and output register
// Scales the modulator sum by the index (or its sine), turns the result into
// a phase offset, reads the carrier sine, applies the gain, rounds and
// saturates, and holds the result item until the sink takes it.
// ============================================================================
`default_nettype none

module pmv_mix #(
    parameter int SUM_BITS = 19
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [SUM_BITS-1:0]            i_sum,
    input  wire logic [pmv_pkg::PHASE_BITS-1:0]        i_carrier,
    input  wire logic signed [pmv_pkg::INDEX_BITS-1:0] i_mod_index,
    input  wire logic                                  i_sine_of_index,
    input  wire logic [pmv_pkg::GAIN_BITS-1:0]         i_out_gain,
    input  wire logic                                  i_tready,
    output logic                                       o_tvalid,
    output logic [pmv_pkg::SAMPLE_BITS-1:0]            o_tdata,
    output logic                                       o_done
);

    localparam int IDX_PROD_BITS = pmv_pkg::INDEX_BITS + 31;
    localparam int RAD_PROD_BITS = SUM_BITS + pmv_pkg::INDEX_BITS;
    localparam int RAD_BITS      = RAD_PROD_BITS - pmv_pkg::RAD_FRAC_BITS;
    localparam int MP_PROD_BITS  = RAD_BITS + 31;
    localparam int Y_BITS        = pmv_pkg::SINE_BITS + pmv_pkg::GAIN_BITS + 1;
    localparam int YR_BITS       = Y_BITS - pmv_pkg::OUT_SHIFT;
    localparam int SB            = pmv_pkg::SAMPLE_BITS;

    localparam logic signed [YR_BITS-1:0] SAT_MAX = YR_BITS'((1 << (SB - 1)) - 1);
    localparam logic signed [YR_BITS-1:0] SAT_MIN = -YR_BITS'(1 << (SB - 1));
    localparam logic signed [Y_BITS-1:0]  ROUND_HALF = Y_BITS'(1 << (pmv_pkg::OUT_SHIFT - 1));

    logic signed [IDX_PROD_BITS-1:0]           w_idx_prod;
    logic [pmv_pkg::IDX_BITS-1:0]              r_idx;
    logic signed [pmv_pkg::SINE_BITS-1:0]      w_idx_sine;
    logic signed [pmv_pkg::INDEX_BITS-1:0]     r_scale;
    logic signed [RAD_PROD_BITS-1:0]           r_rad_prod;
    logic signed [RAD_BITS-1:0]                w_rad;
    logic signed [MP_PROD_BITS-1:0]            w_mp_prod;
    logic [pmv_pkg::PHASE_BITS-1:0]            r_mod_phase;
    logic [pmv_pkg::PHASE_BITS-1:0]            w_total;
    logic signed [pmv_pkg::SINE_BITS-1:0]      w_out_sine;
    logic signed [Y_BITS-1:0]                  r_y;
    logic signed [Y_BITS-1:0]                  w_y_round;
    logic signed [YR_BITS-1:0]                 w_yr;
    logic [SB-1:0]                             w_sat;
    logic                                      r_v1;
    logic                                      r_v2;
    logic                                      r_pend;
    logic                                      r_tvalid;
    logic [SB-1:0]                             r_tdata;
    logic                                      w_load;

    // Track the scale from the current index every cycle
    assign w_idx_prod = i_mod_index * pmv_pkg::INV_TWO_PI;
    assign w_idx_sine = pmv_pkg::sine_lookup(r_idx);

    always_ff @(posedge i_clk) begin
        r_idx <= w_idx_prod[pmv_pkg::RAD_PHASE_TOP -: pmv_pkg::IDX_BITS];
        if (i_sine_of_index) begin
            r_scale <= {{3{w_idx_sine[pmv_pkg::SINE_BITS-1]}}, w_idx_sine, 5'b00000};
        end else begin
            r_scale <= i_mod_index;
        end
    end

    // Modulation in radians, then as a phase offset
    assign w_rad     = r_rad_prod[RAD_PROD_BITS-1:pmv_pkg::RAD_FRAC_BITS];
    assign w_mp_prod = w_rad * pmv_pkg::INV_TWO_PI;

    // Carrier sine and gain
    assign w_total    = i_carrier + r_mod_phase;
    assign w_out_sine = pmv_pkg::sine_lookup(
                            w_total[pmv_pkg::PHASE_BITS-1 -: pmv_pkg::IDX_BITS]);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad_prod <= i_sum * r_scale;
        end
        if (r_v1) begin
            r_mod_phase <= w_mp_prod[pmv_pkg::RAD_PHASE_TOP:pmv_pkg::RAD_PHASE_LOW];
        end
        if (r_v2) begin
            r_y <= w_out_sine * $signed({1'b0, i_out_gain});
        end
    end

    // Round half up and saturate to the sample width
    assign w_y_round = r_y + ROUND_HALF;
    assign w_yr      = w_y_round[Y_BITS-1:pmv_pkg::OUT_SHIFT];

    always_comb begin
        if (w_yr > SAT_MAX) begin
            w_sat = SAT_MAX[SB-1:0];
        end else if (w_yr < SAT_MIN) begin
            w_sat = SAT_MIN[SB-1:0];
        end else begin
            w_sat = w_yr[SB-1:0];
        end
    end

    assign w_load = r_pend && (!r_tvalid || i_tready);

    // Stage flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_pend   <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_pend <= 1'b1;
            end else if (w_load) begin
                r_pend <= 1'b0;
            end
            if (w_load) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_tdata <= w_sat;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_done   = w_load;

endmodule

`default_nettype wire

[design/phase_modulation_voice.sv]
// ============================================================================
// phase_modulation_voice: phase-modulation synthesis voice
// One carrier and a chain of modulator cells; one output sample per item.
// ============================================================================
// Each input item is one sample tick carrying a signed 17-bit index step at the
// scale of the Q4.20 index; each yields one signed Q1.15 sample. The modulators
// sit in a chain of MAX_OSCILLATORS-1 cells that the sample token crosses one
// cell per cycle, followed by a four-stage mix path (index scaling, phase
// offset, carrier sine with gain, round and saturate). The voice takes no new
// item until the result of the last one is loaded into the output register
// and the settle counter has run down after it. A result waiting in the
// output register holds the final mix stage, and with it the next item,
// until the sink takes it. Any configuration write also holds the input
// while the index scale settles. Writing start_index reloads the modulation
// index at once.
// ============================================================================
`default_nettype none

module phase_modulation_voice #(
    parameter int MAX_OSCILLATORS = pmv_pkg::MAX_OSCILLATORS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input item stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [23:0]                         s_tdata,  // [16:0] index_step
    // Result item stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [15:0]                              m_tdata,  // [15:0] sample_out
    // Configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [pmv_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [pmv_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int SUM_BITS = pmv_pkg::SINE_BITS + $clog2(MAX_OSCILLATORS);
    localparam int PB       = pmv_pkg::PHASE_BITS;
    localparam int CB       = pmv_pkg::COUNT_BITS;
    localparam int IB       = pmv_pkg::INDEX_BITS;

    // Configuration registers
    logic [31:0]            r_base_step;
    logic [31:0]            r_offset_step;
    logic [CB-1:0]          r_num_mods;
    logic                   r_sine_of_index;
    logic [15:0]            r_out_gain;

    // Voice state and control
    logic signed [IB-1:0]                      r_mod_index;
    logic [PB-1:0]                             r_carrier;
    logic signed [pmv_pkg::STEP_BITS-1:0]      r_step;
    logic                                      r_busy;
    logic [1:0]                                r_settle;
    logic                                      r_inj_valid;
    logic [CB-1:0]                             r_inj_rem;
    logic [PB-1:0]                             r_inj_inc;

    logic                   w_accept;
    logic                   w_done;
    logic [CB-1:0]          w_count;
    logic signed [IB:0]     w_next_index;

    // Token chain
    logic                          w_valid [MAX_OSCILLATORS];
    logic [CB-1:0]                 w_rem   [MAX_OSCILLATORS];
    logic [PB-1:0]                 w_inc   [MAX_OSCILLATORS];
    logic signed [SUM_BITS-1:0]    w_sum   [MAX_OSCILLATORS];

    assign s_tready = !r_busy && (r_settle == 2'd0);
    assign w_accept = s_tvalid && s_tready;

    // Clamp the active count to the number of modulator cells
    always_comb begin
        if ({2'b00, r_num_mods} > 5'(MAX_OSCILLATORS - 1)) begin
            w_count = CB'(MAX_OSCILLATORS - 1);
        end else begin
            w_count = r_num_mods;
        end
    end

    assign w_next_index = {r_mod_index[IB-1], r_mod_index}
                        + {{(IB + 1 - pmv_pkg::STEP_BITS){r_step[pmv_pkg::STEP_BITS-1]}}, r_step};

    // Configuration writes and the index update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_step     <= pmv_pkg::RST_BASE_STEP;
            r_offset_step   <= pmv_pkg::RST_OFFSET_STEP;
            r_num_mods      <= pmv_pkg::RST_NUM_MODS;
            r_sine_of_index <= pmv_pkg::RST_SINE_OF_INDEX;
            r_out_gain      <= pmv_pkg::RST_OUT_GAIN;
            r_mod_index     <= pmv_pkg::RST_START_INDEX;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pmv_pkg::REG_BASE_STEP:     r_base_step     <= i_cfg_data;
                    pmv_pkg::REG_OFFSET_STEP:   r_offset_step   <= i_cfg_data;
                    pmv_pkg::REG_NUM_MODS:      r_num_mods      <= i_cfg_data[CB-1:0];
                    pmv_pkg::REG_SINE_OF_INDEX: r_sine_of_index <= i_cfg_data[0];
                    pmv_pkg::REG_START_INDEX: begin
                        r_mod_index   <= i_cfg_data[IB-1:0];
                    end
                    pmv_pkg::REG_OUT_GAIN:      r_out_gain      <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end else if (w_done) begin
                if (w_next_index >
                        $signed({pmv_pkg::INDEX_MAX[IB-1], pmv_pkg::INDEX_MAX})) begin
                    r_mod_index <= pmv_pkg::INDEX_MAX;
                end else if (w_next_index <
                        $signed({pmv_pkg::INDEX_MIN[IB-1], pmv_pkg::INDEX_MIN})) begin
                    r_mod_index <= pmv_pkg::INDEX_MIN;
                end else begin
                    r_mod_index <= w_next_index[IB-1:0];
                end
            end
        end
    end

    // Accept an item: advance the carrier and launch the token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_settle    <= 2'd0;
            r_inj_valid <= 1'b0;
            r_carrier   <= '0;
        end else begin
            r_inj_valid <= w_accept;
            if (w_accept) begin
                r_busy    <= 1'b1;
                r_carrier <= r_carrier + r_base_step[PB-1:0];
            end else if (w_done) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_we || w_done) begin
                r_settle <= 2'd2;
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_step    <= s_tdata[pmv_pkg::STEP_BITS-1:0];
            r_inj_rem <= w_count;
            r_inj_inc <= {r_base_step[PB-2:0], 1'b0} + r_offset_step[PB-1:0];
        end
    end

    assign w_valid[0] = r_inj_valid;
    assign w_rem[0]   = r_inj_rem;
    assign w_inc[0]   = r_inj_inc;
    assign w_sum[0]   = '0;

    // Modulator cells
    for (genvar g = 1; g < MAX_OSCILLATORS; g++) begin : g_cell
        pmv_cell #(
            .SUM_BITS (SUM_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_valid     (w_valid[g-1]),
            .i_remaining (w_rem[g-1]),
            .i_inc       (w_inc[g-1]),
            .i_sum       (w_sum[g-1]),
            .i_base_step (r_base_step[PB-1:0]),
            .o_valid     (w_valid[g]),
            .o_remaining (w_rem[g]),
            .o_inc       (w_inc[g]),
            .o_sum       (w_sum[g])
        );
    end

    // Mix path and output register
    pmv_mix #(
        .SUM_BITS (SUM_BITS)
    ) u_mix (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_valid[MAX_OSCILLATORS-1]),
        .i_sum           (w_sum[MAX_OSCILLATORS-1]),
        .i_carrier       (r_carrier),
        .i_mod_index     (r_mod_index),
        .i_sine_of_index (r_sine_of_index),
        .i_out_gain      (r_out_gain),
        .i_tready        (m_tready),
        .o_tvalid        (m_tvalid),
        .o_tdata         (m_tdata),
        .o_done          (w_done)
    );

endmodule

`default_nettype wire
